>>> hw/rtl/spwp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample phase window picker package
// Shared widths, status codes, lane result and control types, mask rotate helper.
// ----------------------------------------------------------------------------
package spwp_pkg;

	localparam int PHASE_COUNT = 16;
	localparam int PHASE_W     = $clog2(PHASE_COUNT);
	localparam int LEN_W       = $clog2(PHASE_COUNT + 1);
	localparam int RANK_W      = $clog2(PHASE_COUNT + 1);

	typedef logic [PHASE_COUNT-1:0] mask_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_CENTER  = 2'd0,
		ST_DEFAULT = 2'd1,
		ST_NONE    = 2'd2
	} status_t;

	// what one lane found: a run that starts at its phase
	typedef struct packed {
		logic                 valid;
		logic [LEN_W-1:0]     len;
		logic [RANK_W-1:0]    rank;
		logic [PHASE_W-1:0]   start;
	} lane_res_t;

	// per-request control that travels alongside the lanes
	typedef struct packed {
		logic valid;
		logic all_pass;
		logic none_pass;
	} ctl_t;

	// rotate right by k: bit j of the result is bit (j + k) mod PHASE_COUNT
	function automatic mask_t rot_mask(input mask_t m, input logic [PHASE_W-1:0] k);
		mask_t               r;
		logic [PHASE_W-1:0]  idx;
		for (int j = 0; j < PHASE_COUNT; j++) begin
			idx  = k + PHASE_W'(j);
			r[j] = m[idx];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/sample_phase_window_picker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample phase window picker
// Chooses the center of the longest passing window in a tuning pass mask.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive pass_mask and raise start; the request is taken
//   at a clock edge with start high and busy low. busy stays low, so a new
//   mask can be taken every cycle.
//   Result channel: done is high for exactly one cycle with sample_phase,
//   tune_status and window_length. The receiver cannot stall; results are
//   never held.
//   Config channel: cfg_valid/cfg_ready/cfg_data write default_phase, the
//   phase used when every phase passes. cfg_ready is always high. Write it
//   only while no request is in flight.
//   Pipeline: a request passes the input register, the registered per-phase
//   lanes and the registered merge tree before done rises.
//   Throughput: one mask per cycle; one lane per phase works in parallel and
//   a compare tree over the lanes sets the cycle time.
//   Reset: arst_n clears the pipeline valids and default_phase to 0.
// ----------------------------------------------------------------------------
module sample_phase_window_picker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [15:0]                   pass_mask,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [3:0]                    cfg_data,
	output logic                               done,
	output logic [3:0]                         sample_phase,
	output logic [1:0]                         tune_status,
	output logic [4:0]                         window_length
);

	localparam int N = spwp_pkg::PHASE_COUNT;

	logic                          valid_s1;
	spwp_pkg::mask_t               mask_s1;
	spwp_pkg::ctl_t                ctl_s2;
	spwp_pkg::lane_res_t           lane_s2 [N];
	logic [spwp_pkg::PHASE_W-1:0]  default_phase_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_phase_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			default_phase_q <= cfg_data;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		mask_s1 <= pass_mask;
	end

	// control alongside the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2.valid     <= valid_s1;
			ctl_s2.all_pass  <= &mask_s1;
			ctl_s2.none_pass <= ~|mask_s1;
		end
	end

	// one lane per phase
	for (genvar g = 0; g < N; g++) begin : g_lane
		spwp_lane u_lane (
			.clk      (clk),
			.rot_mask (spwp_pkg::rot_mask(mask_s1, spwp_pkg::PHASE_W'(g))),
			.lane_idx (spwp_pkg::PHASE_W'(g)),
			.res_s2   (lane_s2[g])
		);
	end

	spwp_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.lane_s2       (lane_s2),
		.ctl_s2        (ctl_s2),
		.default_phase (default_phase_q),
		.done_q        (done),
		.phase_q       (sample_phase),
		.status_q      (tune_status),
		.len_q         (window_length)
	);

endmodule
`default_nettype wire

>>> hw/rtl/spwp_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Phase lane
// Checks whether a passing run starts at this lane's phase, measures it
// circularly and ranks it; result is registered.
// ----------------------------------------------------------------------------
module spwp_lane (
	input  wire logic                          clk,
	input  wire spwp_pkg::mask_t               rot_mask,
	input  wire logic [spwp_pkg::PHASE_W-1:0]  lane_idx,
	output spwp_pkg::lane_res_t                res_s2
);

	spwp_pkg::lane_res_t              res;
	logic [spwp_pkg::LEN_W-1:0]       len;
	logic [spwp_pkg::LEN_W:0]         reach;
	logic                             wraps;

	// run length: position of the first failing phase at or after this one
	always_comb begin
		len = spwp_pkg::LEN_W'(spwp_pkg::PHASE_COUNT);
		for (int j = spwp_pkg::PHASE_COUNT - 1; j >= 0; j--) begin
			if (!rot_mask[j]) begin
				len = spwp_pkg::LEN_W'(j);
			end
		end
	end

	// a run that crosses the last phase into phase 0 ranks first
	assign reach = (spwp_pkg::LEN_W + 1)'(lane_idx) + (spwp_pkg::LEN_W + 1)'(len);
	assign wraps = reach > (spwp_pkg::LEN_W + 1)'(spwp_pkg::PHASE_COUNT);

	always_comb begin
		res.valid = rot_mask[0] & ~rot_mask[spwp_pkg::PHASE_COUNT-1];
		res.len   = len;
		res.rank  = wraps ? '0 : spwp_pkg::RANK_W'(lane_idx) + 1'b1;
		res.start = lane_idx;
	end

	always_ff @(posedge clk) begin
		res_s2 <= res;
	end

endmodule
`default_nettype wire

>>> hw/rtl/spwp_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lane merge
// Picks the best run over all lanes with a compare tree, forms the window
// center and the status, and registers the result.
// ----------------------------------------------------------------------------
module spwp_merge (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire spwp_pkg::lane_res_t           lane_s2 [spwp_pkg::PHASE_COUNT],
	input  wire spwp_pkg::ctl_t                ctl_s2,
	input  wire logic [spwp_pkg::PHASE_W-1:0]  default_phase,
	output logic                               done_q,
	output logic [spwp_pkg::PHASE_W-1:0]       phase_q,
	output logic [1:0]                         status_q,
	output logic [spwp_pkg::LEN_W-1:0]         len_q
);

	localparam int N = spwp_pkg::PHASE_COUNT;

	spwp_pkg::lane_res_t          tree [2*N-1];
	spwp_pkg::lane_res_t          best;
	logic [spwp_pkg::PHASE_W-1:0] center;
	logic [spwp_pkg::PHASE_W-1:0] phase_d;
	spwp_pkg::status_t            status_d;
	logic [spwp_pkg::LEN_W-1:0]   len_d;

	// longer run wins; equal length goes to the lower rank
	function automatic spwp_pkg::lane_res_t pick(input spwp_pkg::lane_res_t a,
		input spwp_pkg::lane_res_t b);
		logic [spwp_pkg::LEN_W+spwp_pkg::RANK_W:0] ka;
		logic [spwp_pkg::LEN_W+spwp_pkg::RANK_W:0] kb;
		ka = {a.valid, a.len, ~a.rank};
		kb = {b.valid, b.len, ~b.rank};
		return (ka >= kb) ? a : b;
	endfunction

	// compare tree: leaves at N-1 .. 2N-2, root at 0
	always_comb begin
		for (int i = 0; i < N; i++) begin
			tree[N-1+i] = lane_s2[i];
		end
		for (int i = N - 2; i >= 0; i--) begin
			tree[i] = pick(tree[2*i+1], tree[2*i+2]);
		end
	end

	assign best   = tree[0];
	assign center = best.start + spwp_pkg::PHASE_W'(best.len >> 1);

	// special cases first
	always_comb begin
		priority if (ctl_s2.none_pass) begin
			phase_d  = spwp_pkg::PHASE_W'(N - 1);
			status_d = spwp_pkg::ST_NONE;
			len_d    = '0;
		end else if (ctl_s2.all_pass) begin
			phase_d  = default_phase;
			status_d = spwp_pkg::ST_DEFAULT;
			len_d    = spwp_pkg::LEN_W'(N);
		end else begin
			phase_d  = center;
			status_d = spwp_pkg::ST_CENTER;
			len_d    = best.len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		phase_q  <= phase_d;
		status_q <= status_d;
		len_q    <= len_d;
	end

endmodule
`default_nettype wire
